[hw/rtl/tlnef_pkg.sv]
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and constants of the line numbering / escape text filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SHOW_NONPRINTING = 3'd0;
    localparam t_cfg_idx CFG_TAB_CARET        = 3'd1;
    localparam t_cfg_idx CFG_NUMBER_ALL       = 3'd2;
    localparam t_cfg_idx CFG_NUMBER_NONBLANK  = 3'd3;
    localparam t_cfg_idx CFG_SHOW_ENDS        = 3'd4;
    localparam t_cfg_idx CFG_SQUEEZE_BLANK    = 3'd5;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_digit;

    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_DEL    = 8'h7F;
    localparam t_byte CH_CARET  = 8'h5E;
    localparam t_byte CH_QMARK  = 8'h3F;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_M      = 8'h4D;
    localparam t_byte CH_DASH   = 8'h2D;
    localparam t_byte CH_I      = 8'h49;
    localparam t_byte CH_ZERO   = 8'h30;

    localparam t_digit DIGIT_NINE = 4'd9;

    // longest expansion of a visible byte (M-^X)
    localparam int TAIL_MAX = 4;

endpackage

[hw/rtl/text_line_number_escape_filter.sv]
// ----------------------------------------------------------------------------
// text_line_number_escape_filter
// Text filter: optional line numbers, blank-line squeeze, '$' at line ends
// and caret / M- notation for tabs, control and high bytes.
//
// One input byte is taken per transaction and expands into a run of 0 to
// NUMBER_DIGITS+5 output bytes, the last one flagged by o_run_last. The run
// is built combinationally and loaded into an output shift register that
// emits one byte per cycle while i_out_stall is low; a new input byte is
// taken once the run is empty or its last byte leaves, so a one-byte run
// with the output not stalled, or a squeezed blank line, allows one input
// transaction every cycle. The input is stalled while the output shift
// register holds more than the byte leaving in the current cycle. The line
// counter holds NUMBER_DIGITS decimal digits, wrapping to 0 after all nines.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter #(
    parameter int NUMBER_DIGITS = tlnef_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  tlnef_pkg::t_cfg_idx   i_cfg_index,
    input  logic                  i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last
);

    localparam int RUN_MAX = NUMBER_DIGITS + 5;
    localparam int LEN_W   = $clog2(RUN_MAX + 1);

    // configuration registers
    logic r_show_np, r_tab_caret, r_num_all, r_num_nb, r_show_ends, r_squeeze;

    // line state
    tlnef_pkg::t_digit r_digits [NUMBER_DIGITS];
    logic              r_line_start;
    logic              r_last_empty;

    // output run
    tlnef_pkg::t_byte  r_buf [RUN_MAX];
    logic [LEN_W-1:0]  r_len;

    logic in_acc, out_acc;

    assign o_out_valid = (r_len != '0);
    assign o_out_byte  = r_buf[0];
    assign o_run_last  = (r_len == LEN_W'(1));
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_len != '0) && !(out_acc && o_run_last);
    assign in_acc      = i_in_valid && !o_in_stall;

    // ---------------- step decode ----------------
    logic at_start_nl, squeezed, num_every, do_num, is_lf;

    assign is_lf       = (i_data_byte == tlnef_pkg::CH_LF);
    assign at_start_nl = r_line_start && is_lf;
    assign squeezed    = at_start_nl && r_squeeze && r_last_empty;
    assign num_every   = r_num_all && !r_num_nb;
    assign do_num      = at_start_nl ? (!squeezed && num_every)
                                     : (r_line_start && (num_every || r_num_nb));

    // ---------------- line number text and increment ----------------
    tlnef_pkg::t_byte  num_chars [NUMBER_DIGITS];   // in output order
    tlnef_pkg::t_digit n_digits  [NUMBER_DIGITS];

    always_comb begin
        logic lead;
        logic carry;
        lead  = 1'b1;
        carry = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            if (lead && r_digits[i] == '0 && i > 0) begin
                num_chars[NUMBER_DIGITS-1-i] = tlnef_pkg::CH_SPACE;
            end else begin
                lead = 1'b0;
                num_chars[NUMBER_DIGITS-1-i] = tlnef_pkg::CH_ZERO | {4'd0, r_digits[i]};
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (!carry) begin
                n_digits[i] = r_digits[i];
            end else if (r_digits[i] >= tlnef_pkg::DIGIT_NINE) begin
                n_digits[i] = '0;
            end else begin
                n_digits[i] = r_digits[i] + 4'd1;
                carry = 1'b0;
            end
        end
    end

    // ---------------- visible form of the byte ----------------
    tlnef_pkg::t_byte tail [tlnef_pkg::TAIL_MAX];
    logic [2:0]       tail_len;

    always_comb begin
        tlnef_pkg::t_byte c;
        tlnef_pkg::t_byte low;
        c   = i_data_byte;
        low = {1'b0, c[6:0]};
        for (int i = 0; i < tlnef_pkg::TAIL_MAX; i++) begin
            tail[i] = c;
        end
        tail_len = 3'd1;
        if (is_lf) begin
            if (r_show_ends) begin
                tail[0]  = tlnef_pkg::CH_DOLLAR;
                tail[1]  = tlnef_pkg::CH_LF;
                tail_len = 3'd2;
            end else begin
                tail[0]  = tlnef_pkg::CH_LF;
            end
        end else if (r_show_np) begin
            if (c < tlnef_pkg::CH_SPACE) begin
                if (c == tlnef_pkg::CH_TAB && !r_tab_caret) begin
                    tail[0] = c;
                end else begin
                    tail[0]  = tlnef_pkg::CH_CARET;
                    tail[1]  = {3'b010, c[4:0]};
                    tail_len = 3'd2;
                end
            end else if (c < tlnef_pkg::CH_DEL) begin
                tail[0] = c;
            end else if (c == tlnef_pkg::CH_DEL) begin
                tail[0]  = tlnef_pkg::CH_CARET;
                tail[1]  = tlnef_pkg::CH_QMARK;
                tail_len = 3'd2;
            end else begin
                tail[0] = tlnef_pkg::CH_M;
                tail[1] = tlnef_pkg::CH_DASH;
                if (low < tlnef_pkg::CH_SPACE) begin
                    tail[2]  = tlnef_pkg::CH_CARET;
                    tail[3]  = {3'b010, low[4:0]};
                    tail_len = 3'd4;
                end else if (low < tlnef_pkg::CH_DEL) begin
                    tail[2]  = low;
                    tail_len = 3'd3;
                end else begin
                    tail[2]  = tlnef_pkg::CH_CARET;
                    tail[3]  = tlnef_pkg::CH_QMARK;
                    tail_len = 3'd4;
                end
            end
        end else if (c == tlnef_pkg::CH_TAB && r_tab_caret) begin
            tail[0]  = tlnef_pkg::CH_CARET;
            tail[1]  = tlnef_pkg::CH_I;
            tail_len = 3'd2;
        end
    end

    // ---------------- run assembly ----------------
    tlnef_pkg::t_byte n_buf [RUN_MAX];
    logic [LEN_W-1:0] n_len;

    always_comb begin
        int k;
        k = 0;
        for (int i = 0; i < RUN_MAX; i++) begin
            n_buf[i] = tlnef_pkg::CH_SPACE;
            if (do_num) begin
                k = i - NUMBER_DIGITS - 1;
                if (i < NUMBER_DIGITS) begin
                    n_buf[i] = num_chars[i];
                end else if (i == NUMBER_DIGITS) begin
                    n_buf[i] = tlnef_pkg::CH_TAB;
                end else if (k < tlnef_pkg::TAIL_MAX) begin
                    n_buf[i] = tail[2'(k)];
                end
            end else if (i < tlnef_pkg::TAIL_MAX) begin
                n_buf[i] = tail[2'(i)];
            end
        end
        if (squeezed) begin
            n_len = '0;
        end else begin
            n_len = (do_num ? LEN_W'(NUMBER_DIGITS + 1) : LEN_W'(0)) + LEN_W'(tail_len);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_np    <= 1'b0;
            r_tab_caret  <= 1'b0;
            r_num_all    <= 1'b0;
            r_num_nb     <= 1'b0;
            r_show_ends  <= 1'b0;
            r_squeeze    <= 1'b0;
            r_line_start <= 1'b1;
            r_last_empty <= 1'b0;
            r_len        <= '0;
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                r_digits[i] <= (i == 0) ? 4'd1 : 4'd0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tlnef_pkg::CFG_SHOW_NONPRINTING: r_show_np   <= i_cfg_data;
                    tlnef_pkg::CFG_TAB_CARET:        r_tab_caret <= i_cfg_data;
                    tlnef_pkg::CFG_NUMBER_ALL:       r_num_all   <= i_cfg_data;
                    tlnef_pkg::CFG_NUMBER_NONBLANK:  r_num_nb    <= i_cfg_data;
                    tlnef_pkg::CFG_SHOW_ENDS:        r_show_ends <= i_cfg_data;
                    tlnef_pkg::CFG_SQUEEZE_BLANK:    r_squeeze   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_len <= n_len;
                if (at_start_nl) begin
                    r_last_empty <= 1'b1;
                end else begin
                    if (r_line_start) begin
                        r_last_empty <= 1'b0;
                    end
                    r_line_start <= is_lf;
                end
                if (do_num) begin
                    for (int i = 0; i < NUMBER_DIGITS; i++) begin
                        r_digits[i] <= n_digits[i];
                    end
                end
            end else if (out_acc) begin
                r_len <= r_len - LEN_W'(1);
            end
        end
    end

    // payload shift register, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < RUN_MAX; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    // ---------------- assertions ----------------
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_len == '0 || (r_len == LEN_W'(1) && !i_out_stall)))
        else $error("new run loaded over undelivered bytes");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(RUN_MAX))
        else $error("run length out of range");

    a_squeeze_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && squeezed) |=> !o_out_valid)
        else $error("squeezed line produced output");

    a_number_tab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && do_num) |=>
            (r_len > LEN_W'(NUMBER_DIGITS + 1) && r_buf[NUMBER_DIGITS] == tlnef_pkg::CH_TAB))
        else $error("line number run malformed");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits[0] <= tlnef_pkg::DIGIT_NINE && r_digits[NUMBER_DIGITS-1] <= tlnef_pkg::DIGIT_NINE)
        else $error("line counter digit above nine");

endmodule

[test/text_line_number_escape_filter_test.sv]
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_test
// Self-checking bench for the line numbering / escape text filter. A short
// table of directed bytes walks the numbering, squeeze, end marker, tab and
// caret / M- paths. Random text phases under changing register settings
// follow, with random idle cycles on the input and random stalls on the
// output. Every output byte and its run marker is checked against the
// typed value of its table row or against a built-in model of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_line_number_escape_filter_test;

    localparam int NUMBER_DIGITS = tlnef_pkg::NUMBER_DIGITS_DEF;
    localparam int CFG_REGS      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_WAIT      = 19;
    localparam int IDLE_CYCLES   = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 17;
    localparam int DIR_ROWS      = 25;

    // indexes past the last register, writes there must be dropped
    localparam tlnef_pkg::t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam tlnef_pkg::t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam tlnef_pkg::t_byte CARET_OFFSET = 8'h40;
    localparam tlnef_pkg::t_byte HIGH_BIT     = 8'h80;

    // register masks, bit i is register index i
    localparam logic [5:0] M_NONPRINT     = 6'b1 << tlnef_pkg::CFG_SHOW_NONPRINTING;
    localparam logic [5:0] M_TABS         = 6'b1 << tlnef_pkg::CFG_TAB_CARET;
    localparam logic [5:0] M_NUM_ALL      = 6'b1 << tlnef_pkg::CFG_NUMBER_ALL;
    localparam logic [5:0] M_NUM_NONBLANK = 6'b1 << tlnef_pkg::CFG_NUMBER_NONBLANK;
    localparam logic [5:0] M_ENDS         = 6'b1 << tlnef_pkg::CFG_SHOW_ENDS;
    localparam logic [5:0] M_SQUEEZE      = 6'b1 << tlnef_pkg::CFG_SQUEEZE_BLANK;

    localparam logic [5:0] C_PLAIN   = 6'b0;
    localparam logic [5:0] C_NUM_SQ  = M_NUM_ALL | M_ENDS | M_SQUEEZE;
    localparam logic [5:0] C_BOTH    = M_NUM_ALL | M_NUM_NONBLANK;
    localparam logic [5:0] C_NP      = M_NONPRINT;
    localparam logic [5:0] C_NP_TABS = M_NONPRINT | M_TABS;
    localparam logic [5:0] C_TABS    = M_TABS;
    localparam logic [5:0] C_ALL     = 6'h3F;

    localparam tlnef_pkg::t_byte LF  = tlnef_pkg::CH_LF;
    localparam tlnef_pkg::t_byte TAB = tlnef_pkg::CH_TAB;
    localparam tlnef_pkg::t_byte DEL = tlnef_pkg::CH_DEL;

    typedef struct packed {
        tlnef_pkg::t_byte b;
        logic             last;
    } t_out_beat;

    typedef struct packed {
        logic [5:0]       cfg;
        tlnef_pkg::t_byte data;
        logic             typed;
        tlnef_pkg::t_byte want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    tlnef_pkg::t_cfg_idx i_cfg_index = tlnef_pkg::CFG_SHOW_NONPRINTING;
    logic                i_cfg_data = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_data_byte = 8'h00;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [7:0]          o_out_byte;
    logic                o_run_last;

    // model state
    logic [5:0]        cfg_now = 6'b0;
    tlnef_pkg::t_digit line_digits [NUMBER_DIGITS];
    logic              mdl_line_start = 1'b1;
    logic              prev_line_empty = 1'b0;
    tlnef_pkg::t_byte  run_bytes [$];
    t_out_beat         out_beats_due [$];

    logic              in_no_idle = 1'b0;
    logic              out_no_idle = 1'b0;
    logic              spare_toggle = 1'b0;
    logic              out_take = 1'b0;
    tlnef_pkg::t_byte  out_seen_byte;
    logic              out_seen_last;
    int                stall_left = 0;
    int                err_cnt = 0;
    int                items_sent = 0;
    int                beats_seen = 0;
    int                cfg_loads = 0;
    int                cycle_cnt = 0;

    // typed rows are single-byte runs whose value is plain to see
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{C_PLAIN,   8'h41, 1'b1, 8'h41},
        '{C_PLAIN,   8'hFF, 1'b1, 8'hFF},
        '{C_PLAIN,   8'h00, 1'b1, 8'h00},
        '{C_PLAIN,   LF,    1'b1, LF},
        '{C_PLAIN,   LF,    1'b1, LF},
        '{C_NUM_SQ,  LF,    1'b0, 8'h00},   // squeezed, no output
        '{C_NUM_SQ,  8'h78, 1'b0, 8'h00},
        '{C_NUM_SQ,  LF,    1'b0, 8'h00},
        '{C_NUM_SQ,  LF,    1'b0, 8'h00},
        '{C_NUM_SQ,  LF,    1'b0, 8'h00},   // squeezed again
        '{C_BOTH,    LF,    1'b0, 8'h00},   // nonblank wins: empty line unnumbered
        '{C_BOTH,    8'h62, 1'b0, 8'h00},
        '{C_BOTH,    TAB,   1'b0, 8'h00},
        '{C_BOTH,    LF,    1'b0, 8'h00},
        '{C_NP,      TAB,   1'b1, TAB},     // raw tab while tabs are not shown
        '{C_NP,      8'h01, 1'b0, 8'h00},
        '{C_NP,      DEL,   1'b0, 8'h00},
        '{C_NP,      8'h89, 1'b0, 8'h00},   // M-^I
        '{C_NP,      8'hFF, 1'b0, 8'h00},
        '{C_NP,      8'hC1, 1'b0, 8'h00},
        '{C_NP,      8'h9F, 1'b0, 8'h00},
        '{C_NP_TABS, TAB,   1'b0, 8'h00},
        '{C_NP_TABS, 8'h89, 1'b0, 8'h00},
        '{C_TABS,    TAB,   1'b0, 8'h00},
        '{C_TABS,    8'h80, 1'b1, 8'h80}
    };

    text_line_number_escape_filter #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        int i;
        for (i = 0; i < NUMBER_DIGITS; i++) begin
            line_digits[i] = '0;
        end
        line_digits[0] = 4'd1;
    end

    // ------------------------------------------------------------------------
    // filter model
    // ------------------------------------------------------------------------
    function automatic void put_byte(tlnef_pkg::t_byte b);
        run_bytes = {run_bytes, b};
    endfunction

    function automatic void emit_line_number();
        int   i;
        logic lead;
        logic carry;
        tlnef_pkg::t_digit d;
        lead = 1'b1;
        for (i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            d = line_digits[i];
            if (lead && d == 0 && i > 0) begin
                put_byte(tlnef_pkg::CH_SPACE);
            end else begin
                lead = 1'b0;
                put_byte(tlnef_pkg::t_byte'(tlnef_pkg::CH_ZERO + tlnef_pkg::t_byte'(
                    d > tlnef_pkg::DIGIT_NINE ? tlnef_pkg::DIGIT_NINE : d)));
            end
        end
        put_byte(tlnef_pkg::CH_TAB);
        carry = 1'b1;
        for (i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (line_digits[i] >= tlnef_pkg::DIGIT_NINE) begin
                    line_digits[i] = '0;
                end else begin
                    line_digits[i] = line_digits[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    endfunction

    function automatic void emit_caret(tlnef_pkg::t_byte c);
        put_byte(tlnef_pkg::CH_CARET);
        put_byte(tlnef_pkg::t_byte'(c + CARET_OFFSET));
    endfunction

    function automatic void emit_visible(tlnef_pkg::t_byte c);
        tlnef_pkg::t_byte lo;
        if (cfg_now[tlnef_pkg::CFG_SHOW_NONPRINTING]) begin
            if (c >= tlnef_pkg::CH_SPACE) begin
                if (c < tlnef_pkg::CH_DEL) begin
                    put_byte(c);
                end else if (c == tlnef_pkg::CH_DEL) begin
                    put_byte(tlnef_pkg::CH_CARET);
                    put_byte(tlnef_pkg::CH_QMARK);
                end else begin
                    lo = tlnef_pkg::t_byte'(c - HIGH_BIT);
                    put_byte(tlnef_pkg::CH_M);
                    put_byte(tlnef_pkg::CH_DASH);
                    if (lo >= tlnef_pkg::CH_SPACE) begin
                        if (lo < tlnef_pkg::CH_DEL) begin
                            put_byte(lo);
                        end else begin
                            put_byte(tlnef_pkg::CH_CARET);
                            put_byte(tlnef_pkg::CH_QMARK);
                        end
                    end else begin
                        emit_caret(lo);   // high tab lands here too: M-^I
                    end
                end
            end else if (c == tlnef_pkg::CH_TAB && !cfg_now[tlnef_pkg::CFG_TAB_CARET]) begin
                put_byte(tlnef_pkg::CH_TAB);
            end else begin
                emit_caret(c);
            end
        end else if (c == tlnef_pkg::CH_TAB && cfg_now[tlnef_pkg::CFG_TAB_CARET]) begin
            put_byte(tlnef_pkg::CH_CARET);
            put_byte(tlnef_pkg::CH_I);
        end else begin
            put_byte(c);
        end
    endfunction

    // leaves the run of one input byte in run_bytes
    function automatic void predict_filter_run(tlnef_pkg::t_byte c);
        logic num_every;
        num_every = cfg_now[tlnef_pkg::CFG_NUMBER_ALL] && !cfg_now[tlnef_pkg::CFG_NUMBER_NONBLANK];
        run_bytes.delete();
        if (mdl_line_start && c == tlnef_pkg::CH_LF) begin
            if (!(cfg_now[tlnef_pkg::CFG_SQUEEZE_BLANK] && prev_line_empty)) begin
                if (num_every) emit_line_number();
                if (cfg_now[tlnef_pkg::CFG_SHOW_ENDS]) put_byte(tlnef_pkg::CH_DOLLAR);
                put_byte(tlnef_pkg::CH_LF);
                prev_line_empty = 1'b1;
            end
        end else begin
            if (mdl_line_start) begin
                prev_line_empty = 1'b0;
                if (num_every || cfg_now[tlnef_pkg::CFG_NUMBER_NONBLANK]) emit_line_number();
                mdl_line_start = 1'b0;
            end
            if (c == tlnef_pkg::CH_LF) begin
                if (cfg_now[tlnef_pkg::CFG_SHOW_ENDS]) put_byte(tlnef_pkg::CH_DOLLAR);
                put_byte(tlnef_pkg::CH_LF);
                mdl_line_start = 1'b1;
            end else begin
                emit_visible(c);
            end
        end
    endfunction

    // mostly text lines, with runs of empty lines, tabs, controls and high bytes
    function automatic tlnef_pkg::t_byte random_text_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 22) return tlnef_pkg::CH_LF;
        if (sel < 30) return tlnef_pkg::CH_TAB;
        if (sel < 70) return tlnef_pkg::t_byte'($urandom_range(8'h20, 8'h7E));
        if (sel < 78) return tlnef_pkg::t_byte'($urandom_range(8'h00, 8'h1F));
        if (sel < 82) return tlnef_pkg::CH_DEL;
        if (sel < 88) return tlnef_pkg::t_byte'($urandom_range(8'h80, 8'h9F));
        return tlnef_pkg::t_byte'($urandom_range(8'hA0, 8'hFF));
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_byte(input tlnef_pkg::t_byte b, input logic typed,
                             input tlnef_pkg::t_byte want);
        int   gap;
        int   k;
        logic taken;
        t_out_beat beat;
        gap = in_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        taken = 1'b0;
        while (!taken) begin
            // handshake inputs are settled at the falling edge
            @(negedge i_clk);
            if (!o_in_stall) begin
                taken = 1'b1;
                items_sent++;
                predict_filter_run(b);
                if (typed) begin
                    beat.b        = want;
                    beat.last     = 1'b1;
                    out_beats_due = {out_beats_due, beat};
                end else begin
                    for (k = 0; k < run_bytes.size(); k++) begin
                        beat.b        = run_bytes[k];
                        beat.last     = (k == run_bytes.size() - 1);
                        out_beats_due = {out_beats_due, beat};
                    end
                end
            end
            @(posedge i_clk);
        end
    endtask

    // a squeezed line leaves nothing due, so allow some cycles past the last byte
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (out_beats_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [5:0] word);
        int i;
        for (i = 0; i < CFG_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= tlnef_pkg::t_cfg_idx'(i);
            i_cfg_data  <= word[i];
            @(posedge i_clk);
        end
        i_cfg_index  <= spare_toggle ? CFG_SPARE_HI : CFG_SPARE_LO;
        i_cfg_data   <= 1'($urandom_range(0, 1));
        spare_toggle = ~spare_toggle;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = word;
        cfg_loads++;
    endtask

    initial begin
        int row;
        int phase;
        int n;
        logic [5:0] cfg_word;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_rows[row].cfg != cfg_now) begin
                wait_idle();
                load_config(dir_rows[row].cfg);
            end
            send_byte(dir_rows[row].data, dir_rows[row].typed, dir_rows[row].want);
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == 0)      cfg_word = C_ALL;
            else if (phase == 1) cfg_word = C_PLAIN;
            else                 cfg_word = 6'($urandom_range(0, 63));
            wait_idle();
            load_config(cfg_word);
            in_no_idle  = ($urandom_range(0, 3) == 0);
            out_no_idle = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_byte(random_text_byte(), 1'b0, 8'h00);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d input bytes under %0d register settings, checked %0d output bytes.",
                 items_sent, cfg_loads + 1, beats_seen);
        $display("Covered numbering, squeeze, end markers, tabs and caret / M- notation.");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side: stalls and checking
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_take      = i_rst_n && o_out_valid && !i_out_stall;
        out_seen_byte = o_out_byte;
        out_seen_last = o_run_last;
    end

    always @(posedge i_clk) begin
        t_out_beat due;
        if (out_take) begin
            beats_seen++;
            if (out_beats_due.size() == 0) begin
                err_cnt++;
                $display("%0t: output transaction with nothing due: byte %h last %b",
                         $time, out_seen_byte, out_seen_last);
            end else begin
                due = out_beats_due.pop_front();
                if (out_seen_byte !== due.b) begin
                    err_cnt++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, due.b, out_seen_byte);
                end
                if (out_seen_last !== due.last) begin
                    err_cnt++;
                    $display("%0t: run_last expected %b actual %b",
                             $time, due.last, out_seen_last);
                end
            end
            stall_left = out_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d output bytes still due",
                     cycle_cnt, out_beats_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

[filelist.f]
hw/rtl/tlnef_pkg.sv
hw/rtl/text_line_number_escape_filter.sv
test/text_line_number_escape_filter_test.sv
